// ===== rtl/mtl_pkg.sv =====
// Shared types, codes and character classes for the marked token lexer.
package mtl_pkg;

   // Record types on the result channel
   localparam logic [1:0] REC_TOKEN = 2'd0;
   localparam logic [1:0] REC_BODY  = 2'd1;
   localparam logic [1:0] REC_ERROR = 2'd2;

   // Token kinds
   localparam logic [4:0] TK_END       = 5'd0;
   localparam logic [4:0] TK_WORD      = 5'd1;
   localparam logic [4:0] TK_NAME      = 5'd2;
   localparam logic [4:0] TK_WRITTEN   = 5'd3;
   localparam logic [4:0] TK_ESCAPE    = 5'd4;
   localparam logic [4:0] TK_DOT       = 5'd5;
   localparam logic [4:0] TK_COMMA     = 5'd6;
   localparam logic [4:0] TK_SEMICOLON = 5'd7;
   localparam logic [4:0] TK_COLON     = 5'd8;
   localparam logic [4:0] TK_EQUALS    = 5'd9;
   localparam logic [4:0] TK_LBRACKET  = 5'd10;
   localparam logic [4:0] TK_RBRACKET  = 5'd11;
   localparam logic [4:0] TK_LBRACE    = 5'd12;
   localparam logic [4:0] TK_RBRACE    = 5'd13;
   localparam logic [4:0] TK_LPAREN    = 5'd14;
   localparam logic [4:0] TK_RPAREN    = 5'd15;
   localparam logic [4:0] TK_PLUS      = 5'd16;
   localparam logic [4:0] TK_MINUS     = 5'd17;
   localparam logic [4:0] TK_SLASH     = 5'd18;
   localparam logic [4:0] TK_LESS      = 5'd19;
   localparam logic [4:0] TK_GREATER   = 5'd20;
   localparam logic [4:0] TK_LESSEQ    = 5'd21;
   localparam logic [4:0] TK_GREATEREQ = 5'd22;
   localparam logic [4:0] TK_EQEQ      = 5'd23;
   localparam logic [4:0] TK_BANGEQ    = 5'd24;

   // Error codes
   localparam logic [2:0] ERR_UNKNOWN  = 3'd0;
   localparam logic [2:0] ERR_UNCLOSED = 3'd1;
   localparam logic [2:0] ERR_DQUOTE   = 3'd2;
   localparam logic [2:0] ERR_ESCAPE   = 3'd3;
   localparam logic [2:0] ERR_NUMBER   = 3'd4;
   localparam logic [2:0] ERR_BANG     = 3'd5;
   localparam logic [2:0] ERR_NONASCII = 3'd6;

   // Input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOT  = 1'b1;

   // Characters of interest
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_HIGH   = 8'h80;

   // Scanner modes, one-hot
   typedef enum logic [14:0] {
      M_IDLE      = 15'b000000000000001,
      M_COMMENT   = 15'b000000000000010,
      M_MARK      = 15'b000000000000100,
      M_MARK_BSL  = 15'b000000000001000,
      M_BSL       = 15'b000000000010000,
      M_DQUOTE    = 15'b000000000100000,
      M_WORD      = 15'b000000001000000,
      M_WORD_HYPH = 15'b000000010000000,
      M_DIGITS    = 15'b000000100000000,
      M_NONASCII  = 15'b000001000000000,
      M_EQ        = 15'b000010000000000,
      M_LT        = 15'b000100000000000,
      M_GT        = 15'b001000000000000,
      M_BANG      = 15'b010000000000000,
      M_DONE      = 15'b100000000000000
   } mode_type;

   // One result record
   typedef struct packed {
      logic [1:0]  record;
      logic [4:0]  token_kind;
      logic [2:0]  error_code;
      logic [15:0] span_begin;
      logic [15:0] span_end;
      logic [7:0]  body_char;
      logic        last;
   } rec_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic word_go(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   // Single-character punctuation; zero when the byte is not one
   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      k = 5'd0;
      case (c)
         8'h2E:   k = TK_DOT;
         8'h2C:   k = TK_COMMA;
         8'h3B:   k = TK_SEMICOLON;
         8'h3A:   k = TK_COLON;
         8'h5B:   k = TK_LBRACKET;
         8'h5D:   k = TK_RBRACKET;
         8'h7B:   k = TK_LBRACE;
         8'h7D:   k = TK_RBRACE;
         8'h28:   k = TK_LPAREN;
         8'h29:   k = TK_RPAREN;
         8'h2B:   k = TK_PLUS;
         8'h2D:   k = TK_MINUS;
         8'h2F:   k = TK_SLASH;
         default: k = 5'd0;
      endcase
      return k;
   endfunction

   function automatic rec_type make_tok(input logic [4:0] k, input logic [15:0] b,
                                        input logic [15:0] e, input logic [7:0] ch);
      rec_type r;
      r = '{record: REC_TOKEN, token_kind: k, error_code: 3'd0, span_begin: b,
            span_end: e, body_char: ch, last: 1'b0};
      return r;
   endfunction

   function automatic rec_type make_err(input logic [2:0] code, input logic [15:0] b,
                                        input logic [15:0] e);
      rec_type r;
      r = '{record: REC_ERROR, token_kind: 5'd0, error_code: code, span_begin: b,
            span_end: e, body_char: 8'd0, last: 1'b0};
      return r;
   endfunction

   function automatic rec_type make_body(input logic [7:0] ch);
      rec_type r;
      r = '{record: REC_BODY, token_kind: 5'd0, error_code: 3'd0, span_begin: 16'd0,
            span_end: 16'd0, body_char: ch, last: 1'b0};
      return r;
   endfunction

endpackage

// ===== rtl/marked_token_lexer_unit.sv =====
// Marked token lexer: byte-wise scanner with a four-record result queue.
// A byte's records are written into the result queue when the byte is transferred;
// rsp offers the queue head. One byte per cycle while each byte yields at most one
// record and rsp_ready stays high; the result channel moves one record per cycle.
// A byte is taken while the four-record queue holds at most one record after this cycle.
// Reset (synchronous): scanner between tokens, offsets zero, result queue empty.
module marked_token_lexer_unit #(
   parameter int POS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record,
   output logic [4:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_span_begin,
   output logic [15:0] rsp_span_end,
   output logic [7:0]  rsp_body_char,
   output logic        rsp_last
);
   import mtl_pkg::*;

   localparam int QD = 4;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] hyph_ff, hyph_in;
   logic                star_ff, star_in;
   rec_type             q_ff [QD];
   rec_type             q_in [QD];
   logic [2:0]          qcnt_ff, qcnt_in;

   logic                acc, pop;
   logic [2:0]          base;
   logic [POS_BITS-1:0] nx;
   logic [15:0]         p16, nx16, st16, hy16;
   logic [7:0]          b, mark_ch;

   // idle-scan results for the current byte
   logic                id_has, id_start, id_star_set, id_star_val;
   mode_type            id_mode;
   rec_type             id_rec;

   // in-mark results for the current byte
   logic                mk_has;
   mode_type            mk_mode;
   rec_type             mk_rec;

   rec_type             res [3];
   logic [1:0]          n;

   // Handshake and offsets
   assign pop       = rsp_valid && rsp_ready;
   assign base      = qcnt_ff - {2'd0, pop};
   assign req_ready = base <= 3'd1;
   assign acc       = req_valid && req_ready;
   assign b         = req_char_in;
   assign nx        = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign p16       = 16'(pos_ff);
   assign nx16      = 16'(nx);
   assign st16      = 16'(start_ff);
   assign hy16      = 16'(hyph_ff);
   assign mark_ch   = star_ff ? CH_STAR : CH_QUOTE;

   // Classify a byte read between tokens
   always_comb begin
      logic [4:0] k;
      k           = punct_kind(b);
      id_has      = 1'b0;
      id_rec      = '0;
      id_mode     = M_IDLE;
      id_start    = 1'b0;
      id_star_set = 1'b0;
      id_star_val = 1'b0;
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
         id_has = 1'b0;
      end else if (k != 5'd0) begin
         id_has = 1'b1;
         id_rec = make_tok(k, p16, nx16, 8'd0);
      end else begin
         id_start = 1'b1;
         case (b)
            CH_HASH:   id_mode = M_COMMENT;
            CH_QUOTE: begin
               id_mode     = M_MARK;
               id_star_set = 1'b1;
               id_star_val = 1'b0;
            end
            CH_STAR: begin
               id_mode     = M_MARK;
               id_star_set = 1'b1;
               id_star_val = 1'b1;
            end
            CH_BSL:    id_mode = M_BSL;
            CH_DQUOTE: id_mode = M_DQUOTE;
            CH_EQ:     id_mode = M_EQ;
            CH_LT:     id_mode = M_LT;
            CH_GT:     id_mode = M_GT;
            CH_BANG:   id_mode = M_BANG;
            default: begin
               if (is_alpha(b) || b == CH_UNDER) begin
                  id_mode = M_WORD;
               end else if (is_digit(b)) begin
                  id_mode = M_DIGITS;
               end else if (b >= CH_HIGH) begin
                  id_mode = M_NONASCII;
               end else begin
                  id_has = 1'b1;
                  id_rec = make_err(ERR_UNKNOWN, p16, nx16);
               end
            end
         endcase
      end
   end

   // Read a byte inside a mark body
   always_comb begin
      mk_has  = 1'b1;
      mk_mode = M_IDLE;
      mk_rec  = make_body(b);
      if (b == CH_BSL) begin
         mk_has  = 1'b0;
         mk_mode = M_MARK_BSL;
      end else if (b == mark_ch) begin
         mk_rec = make_tok(star_ff ? TK_WRITTEN : TK_NAME, st16, nx16, 8'd0);
      end else if (b == CH_LF) begin
         mk_rec = make_err(ERR_UNCLOSED, st16, p16);
      end else begin
         mk_mode = M_MARK;
      end
   end

   // Scanner step: next state and up to three records for this item
   always_comb begin
      logic use_idle;
      use_idle = 1'b0;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      hyph_in  = hyph_ff;
      star_in  = star_ff;
      n        = 2'd0;
      res[0]   = '0;
      res[1]   = '0;
      res[2]   = '0;
      if (mode_ff == M_DONE) begin
         n = 2'd0;
      end else if (req_kind == KIND_EOT) begin
         // close whatever is pending, then give End
         unique case (mode_ff)
            M_MARK_BSL: begin
               res[0] = make_body(CH_BSL);
               res[1] = make_err(ERR_UNCLOSED, st16, p16);
               n      = 2'd2;
            end
            M_MARK: begin res[0] = make_err(ERR_UNCLOSED, st16, p16); n = 2'd1; end
            M_BSL:  begin res[0] = make_err(ERR_ESCAPE, st16, p16); n = 2'd1; end
            M_DQUOTE: begin res[0] = make_err(ERR_DQUOTE, st16, p16); n = 2'd1; end
            M_WORD: begin res[0] = make_tok(TK_WORD, st16, p16, 8'd0); n = 2'd1; end
            M_WORD_HYPH: begin
               res[0] = make_tok(TK_WORD, st16, hy16, 8'd0);
               res[1] = make_tok(TK_MINUS, hy16, p16, 8'd0);
               n      = 2'd2;
            end
            M_DIGITS: begin res[0] = make_err(ERR_NUMBER, st16, p16); n = 2'd1; end
            M_NONASCII: begin res[0] = make_err(ERR_NONASCII, st16, p16); n = 2'd1; end
            M_EQ:  begin res[0] = make_tok(TK_EQUALS, st16, p16, 8'd0); n = 2'd1; end
            M_LT:  begin res[0] = make_tok(TK_LESS, st16, p16, 8'd0); n = 2'd1; end
            M_GT:  begin res[0] = make_tok(TK_GREATER, st16, p16, 8'd0); n = 2'd1; end
            M_BANG: begin res[0] = make_err(ERR_BANG, st16, p16); n = 2'd1; end
            default: n = 2'd0;
         endcase
         res[n] = '{record: REC_TOKEN, token_kind: TK_END, error_code: 3'd0,
                    span_begin: p16, span_end: p16, body_char: 8'd0, last: 1'b1};
         n       = n + 2'd1;
         mode_in = M_DONE;
      end else begin
         pos_in = nx;
         unique case (mode_ff) inside
            M_COMMENT: begin
               if (b == CH_LF) mode_in = M_IDLE;
            end
            M_MARK: begin
               mode_in = mk_mode;
               if (mk_has) begin res[0] = mk_rec; n = 2'd1; end
            end
            M_MARK_BSL: begin
               if (b == mark_ch) begin
                  mode_in = M_MARK;
                  res[0]  = make_body(b);
                  n       = 2'd1;
               end else begin
                  res[0]  = make_body(CH_BSL);
                  mode_in = mk_mode;
                  if (mk_has) begin res[1] = mk_rec; n = 2'd2; end
                  else n = 2'd1;
               end
            end
            M_BSL: begin
               if (b == CH_LOW_N || b == CH_LOW_T || b == CH_LOW_R || b == CH_BSL) begin
                  mode_in = M_IDLE;
                  res[0]  = make_tok(TK_ESCAPE, st16, nx16, b);
                  n       = 2'd1;
               end else begin
                  res[0]   = make_err(ERR_ESCAPE, st16, p16);
                  n        = 2'd1;
                  use_idle = 1'b1;
               end
            end
            M_DQUOTE: begin
               if (b == CH_DQUOTE) begin
                  mode_in = M_IDLE;
                  res[0]  = make_err(ERR_DQUOTE, st16, nx16);
                  n       = 2'd1;
               end else if (b == CH_LF) begin
                  mode_in = M_IDLE;
                  res[0]  = make_err(ERR_DQUOTE, st16, p16);
                  n       = 2'd1;
               end
            end
            M_WORD: begin
               if (b == CH_MINUS) begin
                  hyph_in = pos_ff;
                  mode_in = M_WORD_HYPH;
               end else if (!word_go(b)) begin
                  res[0]   = make_tok(TK_WORD, st16, p16, 8'd0);
                  n        = 2'd1;
                  use_idle = 1'b1;
               end
            end
            M_WORD_HYPH: begin
               if (word_go(b)) begin
                  mode_in = M_WORD;
               end else begin
                  res[0]   = make_tok(TK_WORD, st16, hy16, 8'd0);
                  res[1]   = make_tok(TK_MINUS, hy16, p16, 8'd0);
                  n        = 2'd2;
                  use_idle = 1'b1;
               end
            end
            M_DIGITS: begin
               if (!is_digit(b)) begin
                  res[0]   = make_err(ERR_NUMBER, st16, p16);
                  n        = 2'd1;
                  use_idle = 1'b1;
               end
            end
            M_NONASCII: begin
               if (b < CH_HIGH) begin
                  res[0]   = make_err(ERR_NONASCII, st16, p16);
                  n        = 2'd1;
                  use_idle = 1'b1;
               end
            end
            M_EQ, M_LT, M_GT: begin
               if (b == CH_EQ) begin
                  mode_in = M_IDLE;
                  res[0]  = make_tok((mode_ff == M_EQ) ? TK_EQEQ :
                                     (mode_ff == M_LT) ? TK_LESSEQ : TK_GREATEREQ,
                                     st16, nx16, 8'd0);
               end else begin
                  res[0]   = make_tok((mode_ff == M_EQ) ? TK_EQUALS :
                                      (mode_ff == M_LT) ? TK_LESS : TK_GREATER,
                                      st16, p16, 8'd0);
                  use_idle = 1'b1;
               end
               n = 2'd1;
            end
            M_BANG: begin
               if (b == CH_EQ) begin
                  mode_in = M_IDLE;
                  res[0]  = make_tok(TK_BANGEQ, st16, nx16, 8'd0);
               end else begin
                  res[0]   = make_err(ERR_BANG, st16, p16);
                  use_idle = 1'b1;
               end
               n = 2'd1;
            end
            default: use_idle = 1'b1;
         endcase
         // fall back to a fresh token scan of this byte
         if (use_idle) begin
            mode_in = id_mode;
            if (id_start) start_in = pos_ff;
            if (id_star_set) star_in = id_star_val;
            if (id_has) begin
               res[n] = id_rec;
               n      = n + 2'd1;
            end
         end
      end
   end

   // Result queue: drop the head on a transfer, append this item's records
   always_comb begin
      logic [2:0] off;
      rec_type    sh [QD];
      for (int j = 0; j < QD - 1; j++) begin
         sh[j] = pop ? q_ff[j+1] : q_ff[j];
      end
      sh[QD-1] = q_ff[QD-1];
      for (int j = 0; j < QD; j++) begin
         off     = 3'(j) - base;
         q_in[j] = sh[j];
         if (acc && 3'(j) >= base && off < {1'b0, n}) q_in[j] = res[off[1:0]];
      end
      qcnt_in = acc ? base + {1'b0, n} : base;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         hyph_ff  <= '0;
         star_ff  <= 1'b0;
         qcnt_ff  <= 3'd0;
      end else begin
         qcnt_ff <= qcnt_in;
         if (acc) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            hyph_ff  <= hyph_in;
            star_ff  <= star_in;
         end
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      for (int j = 0; j < QD; j++) q_ff[j] <= q_in[j];
   end

   // Drive the head record
   assign rsp_valid      = qcnt_ff != 3'd0;
   assign rsp_record     = q_ff[0].record;
   assign rsp_token_kind = q_ff[0].token_kind;
   assign rsp_error_code = q_ff[0].error_code;
   assign rsp_span_begin = q_ff[0].span_begin;
   assign rsp_span_end   = q_ff[0].span_end;
   assign rsp_body_char  = q_ff[0].body_char;
   assign rsp_last       = q_ff[0].last;

   // Checks
   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset) qcnt_ff <= 3'd4)
      else $error("result queue overfilled");
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_DONE |=> mode_ff == M_DONE)
      else $error("scanner left the finished state");
   a_qcnt_hold: assert property (@(posedge clock) disable iff (reset)
      !pop && !acc |=> $stable(qcnt_ff))
      else $error("queue count moved without a transfer");
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_record == REC_TOKEN && rsp_token_kind == TK_END)
      else $error("final record is not an End token");

endmodule
